// ===== hw/rtl/double_sqrt_bit_by_bit_assert.svh =====
// Assertion macros used by the checker file dsq_checker.sv.
`ifndef DOUBLE_SQRT_BIT_BY_BIT_ASSERT_SVH
`define DOUBLE_SQRT_BIT_BY_BIT_ASSERT_SVH

// An implication checked at every rising clock edge outside reset.
`define DSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// A condition that is checked in the cycle after a trigger.
`define DSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dsq_pkg.sv =====
`default_nettype none
package dsq_pkg;
  // Pipeline shape: each stage resolves RootPerStage root bits.
  localparam int RootBits     = 54;
  localparam int RootPerStage = 3;
  localparam int NumStages    = RootBits / RootPerStage;
  localparam int RemW         = 57;

  localparam logic [1:0] RM_NEAREST = 2'd0;
  localparam logic [1:0] RM_ZERO    = 2'd1;
  localparam logic [1:0] RM_UP      = 2'd2;
  localparam logic [1:0] RM_DOWN    = 2'd3;

  localparam logic [63:0] CanonNan = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] QuietBit = 64'h0008_0000_0000_0000;

  // Control and side data carried alongside the recurrence.
  typedef struct packed {
    logic        vld;
    logic        special;
    logic [63:0] special_bits;
    logic        invalid;
    logic [10:0] exp_field;
    logic [1:0]  rmode;
  } dsq_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/dsq_prep.sv =====
`default_nettype none
// Decodes the operand, handles special values and normalizes the significand.
module dsq_prep (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_vld,
  input  wire logic [63:0]        in_bits,
  input  wire logic [1:0]         rmode,
  output dsq_pkg::dsq_ctl_t       ctl_r,
  output logic [53:0]             rad_r
);
  import dsq_pkg::*;

  logic [10:0] expf;
  logic [51:0] frac;
  logic        neg;
  logic [5:0]  lz;
  logic        lz_found;
  logic [52:0] m_norm;
  logic [11:0] k;
  logic [53:0] m_even;
  dsq_ctl_t    ctl_nxt;

  assign expf = in_bits[62:52];
  assign frac = in_bits[51:0];
  assign neg  = in_bits[63];

  // Leading-zero count of the fraction, used only for subnormals.
  always_comb begin
    lz = 6'd0;
    lz_found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!lz_found && frac[i]) begin
        lz = 6'(51 - i);
        lz_found = 1'b1;
      end
    end
  end

  always_comb begin
    if (expf == 11'd0) begin
      m_norm = {1'b0, frac} << (lz + 6'd1);
      k      = 12'd78 - 12'(lz) - 12'd1;
    end else begin
      m_norm = {1'b1, frac};
      k      = {1'b0, expf} + 12'd77;
    end
    m_even = k[0] ? {m_norm, 1'b0} : {1'b0, m_norm};
  end

  always_comb begin
    ctl_nxt.vld          = in_vld;
    ctl_nxt.special      = 1'b1;
    ctl_nxt.invalid      = 1'b0;
    ctl_nxt.special_bits = in_bits;
    ctl_nxt.exp_field    = 11'(k[11:1] + 11'd473);
    ctl_nxt.rmode        = rmode;
    if (expf == 11'h7FF) begin
      if (frac != 52'd0) begin
        ctl_nxt.special_bits = in_bits | QuietBit;
      end else if (neg) begin
        ctl_nxt.special_bits = CanonNan;
        ctl_nxt.invalid      = 1'b1;
      end
    end else if (expf == 11'd0 && frac == 52'd0) begin
      ctl_nxt.special = 1'b1;
    end else if (neg) begin
      ctl_nxt.special_bits = CanonNan;
      ctl_nxt.invalid      = 1'b1;
    end else begin
      ctl_nxt.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_nxt.vld;
    end
    ctl_r.special      <= ctl_nxt.special;
    ctl_r.special_bits <= ctl_nxt.special_bits;
    ctl_r.invalid      <= ctl_nxt.invalid;
    ctl_r.exp_field    <= ctl_nxt.exp_field;
    ctl_r.rmode        <= ctl_nxt.rmode;
    rad_r              <= m_even;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_stage.sv =====
`default_nettype none
// One pipeline stage of the restoring recurrence: RootPerStage root bits.
module dsq_stage (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dsq_pkg::dsq_ctl_t        ctl_in,
  input  wire logic [53:0]              rad_in,
  input  wire logic [dsq_pkg::RemW-1:0] rem_in,
  input  wire logic [53:0]              q_in,
  output dsq_pkg::dsq_ctl_t             ctl_r,
  output logic [53:0]                   rad_r,
  output logic [dsq_pkg::RemW-1:0]      rem_r,
  output logic [53:0]                   q_r
);
  import dsq_pkg::*;

  logic [RemW-1:0] rem_v;
  logic [RemW-1:0] trial;
  logic [53:0]     q_v;
  logic [53:0]     rad_v;

  // The radicand shifts out two bits per step; zeros follow it.
  always_comb begin
    rem_v = rem_in;
    q_v   = q_in;
    rad_v = rad_in;
    trial = '0;
    for (int i = 0; i < RootPerStage; i++) begin
      rem_v = {rem_v[RemW-3:0], rad_v[53:52]};
      rad_v = {rad_v[51:0], 2'b00};
      trial = RemW'({q_v, 2'b01});
      if (rem_v >= trial) begin
        rem_v = rem_v - trial;
        q_v   = {q_v[52:0], 1'b1};
      end else begin
        q_v   = {q_v[52:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r.vld <= ctl_in.vld;
    end
    ctl_r.special      <= ctl_in.special;
    ctl_r.special_bits <= ctl_in.special_bits;
    ctl_r.invalid      <= ctl_in.invalid;
    ctl_r.exp_field    <= ctl_in.exp_field;
    ctl_r.rmode        <= ctl_in.rmode;
    rad_r <= rad_v;
    rem_r <= rem_v;
    q_r   <= q_v;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_round.sv =====
`default_nettype none
// Rounds the 54-bit root and assembles the result.
module dsq_round (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dsq_pkg::dsq_ctl_t        ctl_in,
  input  wire logic [dsq_pkg::RemW-1:0] rem_in,
  input  wire logic [53:0]              q_in,
  output logic                          out_valid_r,
  output logic [63:0]                   out_bits_r,
  output logic                          out_inexact_r,
  output logic                          out_invalid_r
);
  import dsq_pkg::*;

  logic        guard;
  logic        sticky;
  logic        up;
  logic [52:0] q;
  logic [63:0] res;

  assign guard  = q_in[0];
  assign sticky = rem_in != '0;
  assign q      = q_in[53:1];

  always_comb begin
    case (ctl_in.rmode)
      RM_NEAREST: up = guard && (sticky || q[0]);
      RM_UP:      up = guard || sticky;
      default:    up = 1'b0;
    endcase
    res = {1'b0, ctl_in.exp_field, 52'd0} + {12'd0, q[51:0]} + {63'd0, up};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_in.vld;
    end
    out_bits_r    <= ctl_in.special ? ctl_in.special_bits : res;
    out_inexact_r <= !ctl_in.special && (guard || sticky);
    out_invalid_r <= ctl_in.special && ctl_in.invalid;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/double_sqrt_bit_by_bit.sv =====
`default_nettype none
// Pipelined IEEE 754 binary64 square root.
// Input: pulse start with in_operand_bits while busy is low; busy is tied
// low, so one operand may be issued in every clock cycle.
// Output: out_valid is high for one cycle with out_root_bits, out_inexact
// and out_invalid. The receiver cannot stall, and none is needed since
// the pipeline never holds.
// Pipeline: one decode stage, eighteen recurrence stages of three root
// bits each and one rounding stage, each a register stage. Throughput:
// one result per cycle, set by the recurrence stages, each of which
// owns its own subtractors.
// Configuration: cfg_valid/cfg_ready write the rounding mode
// (0 nearest even, 1 toward zero, 2 upward, 3 downward); cfg_ready is
// always high. Write it only while no request is in flight.
// Reset: synchronous, active low; it empties the pipeline and sets the
// rounding mode to nearest even.
module double_sqrt_bit_by_bit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] in_operand_bits,
  output logic             out_valid,
  output logic [63:0]      out_root_bits,
  output logic             out_inexact,
  output logic             out_invalid,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_rounding_mode
);
  import dsq_pkg::*;

  logic [1:0]      rmode_r;
  dsq_ctl_t        ctl   [NumStages+1];
  logic [53:0]     rad   [NumStages+1];
  logic [RemW-1:0] rem   [NumStages+1];
  logic [53:0]     q     [NumStages+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmode_r <= RM_NEAREST;
    end else if (cfg_valid && cfg_ready) begin
      rmode_r <= cfg_rounding_mode;
    end
  end

  dsq_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_bits (in_operand_bits),
    .rmode   (rmode_r),
    .ctl_r   (ctl[0]),
    .rad_r   (rad[0])
  );
  assign rem[0] = '0;
  assign q[0]   = '0;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    dsq_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_in (ctl[s]),
      .rad_in (rad[s]),
      .rem_in (rem[s]),
      .q_in   (q[s]),
      .ctl_r  (ctl[s+1]),
      .rad_r  (rad[s+1]),
      .rem_r  (rem[s+1]),
      .q_r    (q[s+1])
    );
  end

  dsq_round u_round (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_in        (ctl[NumStages]),
    .rem_in        (rem[NumStages]),
    .q_in          (q[NumStages]),
    .out_valid_r   (out_valid),
    .out_bits_r    (out_root_bits),
    .out_inexact_r (out_inexact),
    .out_invalid_r (out_invalid)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_checker.sv =====
`default_nettype none
`include "double_sqrt_bit_by_bit_assert.svh"
// Port-level checks on the square root block.
module dsq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [63:0] out_root_bits,
  input wire logic        out_inexact,
  input wire logic        out_invalid
);
  import dsq_pkg::*;

  // An invalid result is always the canonical quiet NaN and never inexact.
  `DSQ_ASSERT_IMPL(a_invalid_nan, clk, rst_n, out_valid && out_invalid, out_root_bits == CanonNan && !out_inexact, "invalid result is not the canonical NaN")
  // A rounded result is always a positive number.
  `DSQ_ASSERT_IMPL(a_inexact_pos, clk, rst_n, out_valid && out_inexact, !out_root_bits[63] && !out_invalid, "inexact result has a bad sign")
  // The block never refuses a request.
  `DSQ_ASSERT_IMPL(a_never_busy, clk, rst_n, start, !busy, "busy raised")
  // Every accepted request shows its result after the pipeline latency.
  `DSQ_ASSERT_NEXT(a_latency, clk, rst_n, start && !busy, ##(NumStages + 1) out_valid, "result missing after the pipeline latency")
endmodule

bind double_sqrt_bit_by_bit dsq_checker u_dsq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_root_bits (out_root_bits),
  .out_inexact   (out_inexact),
  .out_invalid   (out_invalid)
);
`default_nettype wire
